### hw/rtl/rbst_pkg.sv
package rbst_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int CW          = COORD_WIDTH;
    localparam int FRAC_BITS   = 16;
    // product of a CW+1 bit difference and a CW bit reciprocal
    localparam int PW          = 2 * CW + 1;
    // quotient bits of 2^32 / d
    localparam int DIV_STEPS   = 33;
    localparam int CNT_W       = $clog2(DIV_STEPS);
    localparam int NUM_AXES    = 3;

    // action codes of an input word
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_TEST  = 1'b1;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic        [CW-1:0] t_umag;

    localparam logic [PW-1:0] POS_LIM = PW'({1'b0, {(CW-1){1'b1}}});
    localparam logic [PW-1:0] NEG_LIM = POS_LIM + PW'(1);
    localparam t_coord        MAXPOS  = t_coord'({1'b0, {(CW-1){1'b1}}});
    localparam t_coord        MINNEG  = t_coord'({1'b1, {(CW-1){1'b0}}});

    // per-axis slab result handed to the merge stage
    typedef struct packed {
        logic   bounded;
        logic   miss;
        t_coord lo;
        t_coord hi;
    } t_slab;

    // signed value from sign and magnitude, saturated to the coordinate range
    function automatic t_coord sat_sm(input logic neg, input logic [PW-1:0] mag);
        t_coord res;
        if (!neg) begin
            res = (mag > POS_LIM) ? MAXPOS : t_coord'(mag[CW-1:0]);
        end else begin
            res = (mag > NEG_LIM) ? MINNEG : t_coord'(-mag[CW-1:0]);
        end
        return res;
    endfunction

endpackage

### hw/rtl/rbst_recip.sv
module rbst_recip
    import rbst_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_umag  i_mag,
    input  logic   i_neg,
    output logic   o_busy,
    output logic   o_done,
    output t_coord o_inv
);

    logic                 r_run, r_done, r_neg;
    logic [CNT_W-1:0]     r_cnt;
    logic [CW-1:0]        r_rem;
    logic [CW:0]          n_rem, rem_sh;
    logic [DIV_STEPS-1:0] r_q;
    t_umag                r_m;
    logic                 qbit;

    // one restoring step of 2^32 / m
    always_comb begin
        rem_sh = {r_rem, (r_cnt == CNT_W'(DIV_STEPS - 1))};
        qbit   = (rem_sh >= {1'b0, r_m});
        n_rem  = qbit ? rem_sh - {1'b0, r_m} : rem_sh;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(DIV_STEPS - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_m   <= i_mag;
            r_neg <= i_neg;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_run) begin
            r_rem <= n_rem[CW-1:0];
            r_q   <= {r_q[DIV_STEPS-2:0], qbit};
        end
    end

    assign o_busy = r_run | r_done;
    assign o_done = r_done;
    assign o_inv  = sat_sm(r_neg, PW'(r_q));

endmodule

### hw/rtl/rbst_lane.sv
module rbst_lane
    import rbst_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_en,
    input  t_coord i_min,
    input  t_coord i_max,
    input  t_coord i_org,
    input  t_coord i_inv,
    input  logic   i_par,
    output t_slab  o_slab
);

    logic signed [CW:0] da, db;
    logic [CW:0]        r1_ma, r1_mb;
    logic               r1_sa, r1_sb, r1_par, r1_miss;
    t_umag              r1_mi;
    logic [PW-1:0]      r2_pa, r2_pb;
    logic               r2_sa, r2_sb, r2_par, r2_miss;
    t_coord             t1, t2;
    t_slab              r3_slab;

    assign da = {i_min[CW-1], i_min} - {i_org[CW-1], i_org};
    assign db = {i_max[CW-1], i_max} - {i_org[CW-1], i_org};

    // stage 1: distance magnitudes, signs, parallel check
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ma   <= da[CW] ? -da : da;
            r1_mb   <= db[CW] ? -db : db;
            r1_sa   <= da[CW] ^ i_inv[CW-1];
            r1_sb   <= db[CW] ^ i_inv[CW-1];
            r1_mi   <= i_inv[CW-1] ? -i_inv : i_inv;
            r1_par  <= i_par;
            r1_miss <= i_par && ((i_org < i_min) || (i_org > i_max));
        end
    end

    // stage 2: products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_pa   <= PW'(r1_ma) * PW'(r1_mi);
            r2_pb   <= PW'(r1_mb) * PW'(r1_mi);
            r2_sa   <= r1_sa;
            r2_sb   <= r1_sb;
            r2_par  <= r1_par;
            r2_miss <= r1_miss;
        end
    end

    assign t1 = sat_sm(r2_sa, r2_pa >> FRAC_BITS);
    assign t2 = sat_sm(r2_sb, r2_pb >> FRAC_BITS);

    // stage 3: saturated times ordered
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_slab.bounded <= !r2_par;
            r3_slab.miss    <= r2_miss;
            r3_slab.lo      <= (t1 < t2) ? t1 : t2;
            r3_slab.hi      <= (t1 < t2) ? t2 : t1;
        end
    end

    assign o_slab = r3_slab;

endmodule

### hw/rtl/rbst_merge.sv
module rbst_merge
    import rbst_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_en,
    input  t_slab  i_slab [NUM_AXES],
    input  t_coord i_time_limit,
    input  t_coord i_min_time,
    output logic   o_hit
);

    logic   bnd, miss, r_hit;
    t_coord entry, exit_t;

    // reduce the axes to one entry and one exit time
    always_comb begin
        bnd    = 1'b0;
        miss   = 1'b0;
        entry  = '0;
        exit_t = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            if (i_slab[i].miss) miss = 1'b1;
            if (i_slab[i].bounded) begin
                if (!bnd || i_slab[i].lo > entry) entry = i_slab[i].lo;
                if (!bnd || i_slab[i].hi < exit_t) exit_t = i_slab[i].hi;
                bnd = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= !miss && (!bnd || ((entry <= exit_t) && (entry < i_time_limit)
                                        && (exit_t > i_min_time)));
        end
    end

    assign o_hit = r_hit;

endmodule

### hw/rtl/ray_box_slab_test.sv
// ray against axis-aligned box, slab method, signed Q16.16
// input channel: i_in_valid / o_in_stall carry one word: action, vec_a, vec_b,
//   time_limit. action 0 loads a ray (origin, direction, time limit), action 1
//   tests a box (min corner in vec_a, max corner in vec_b) against that ray.
// output channel: o_out_valid / i_out_stall carry one hit bit per box test;
//   a load gives no output word.
// config: i_cfg_we writes i_cfg_data into min_time, the lower time bound.
// throughput: one box test per cycle while no load is in progress and the output
//   is not stalled, through a four-stage pipeline of three axis lanes and a
//   merge stage.
// a load waits until the pipeline has drained, then computes the three
//   reciprocals in parallel, each with its own bit-serial divider of 33 steps;
//   the input is stalled after a load is accepted until the dividers are done.
// when the receiver stalls with a result waiting, the whole pipeline holds
//   and the input is stalled in the same cycle.
// reset: the ray becomes all axes parallel at origin zero, time limit zero,
//   min_time zero; the pipeline is emptied.
module ray_box_slab_test
    import rbst_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_stall,
    input  logic   i_action,
    input  t_coord i_vec_a_x,
    input  t_coord i_vec_a_y,
    input  t_coord i_vec_a_z,
    input  t_coord i_vec_b_x,
    input  t_coord i_vec_b_y,
    input  t_coord i_vec_b_z,
    input  t_coord i_time_limit,
    output logic   o_out_valid,
    input  logic   i_out_stall,
    output logic   o_hit,
    input  logic   i_cfg_we,
    input  t_coord i_cfg_data
);

    t_coord                r_org [NUM_AXES];
    t_coord                r_inv [NUM_AXES];
    logic [NUM_AXES-1:0]   r_par;
    t_coord                r_limit, r_min_time;
    logic [3:0]            r_v;
    logic                  en, acc, load_acc, test_acc, busy;
    t_coord                va [NUM_AXES];
    t_coord                vb [NUM_AXES];
    logic [NUM_AXES-1:0]   d_busy, d_done;
    t_coord                d_inv [NUM_AXES];
    t_slab                 slab [NUM_AXES];

    assign va = '{i_vec_a_x, i_vec_a_y, i_vec_a_z};
    assign vb = '{i_vec_b_x, i_vec_b_y, i_vec_b_z};

    // handshake
    assign en         = !(r_v[3] && i_out_stall);
    assign busy       = |d_busy;
    assign o_in_stall = busy || !en || (i_in_valid && (i_action == ACT_LOAD) && (|r_v));
    assign acc        = i_in_valid && !o_in_stall;
    assign load_acc   = acc && (i_action == ACT_LOAD);
    assign test_acc   = acc && (i_action == ACT_TEST);

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[2:0], test_acc};
        end
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_time <= '0;
        end else if (i_cfg_we) begin
            r_min_time <= i_cfg_data;
        end
    end

    // ray state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_par   <= '1;
            r_limit <= '0;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_org[i] <= '0;
                r_inv[i] <= '0;
            end
        end else begin
            if (load_acc) begin
                r_limit <= i_time_limit;
                for (int i = 0; i < NUM_AXES; i++) begin
                    r_org[i] <= va[i];
                    r_par[i] <= (vb[i] == '0);
                end
            end
            for (int i = 0; i < NUM_AXES; i++) begin
                if (d_done[i]) r_inv[i] <= r_par[i] ? '0 : d_inv[i];
            end
        end
    end

    // lanes
    for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
        rbst_recip u_recip (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (load_acc),
            .i_mag   (vb[g][CW-1] ? t_umag'(-vb[g]) : t_umag'(vb[g])),
            .i_neg   (vb[g][CW-1]),
            .o_busy  (d_busy[g]),
            .o_done  (d_done[g]),
            .o_inv   (d_inv[g])
        );

        rbst_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_min  (va[g]),
            .i_max  (vb[g]),
            .i_org  (r_org[g]),
            .i_inv  (r_inv[g]),
            .i_par  (r_par[g]),
            .o_slab (slab[g])
        );
    end

    rbst_merge u_merge (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_slab       (slab),
        .i_time_limit (r_limit),
        .i_min_time   (r_min_time),
        .o_hit        (o_hit)
    );

    assign o_out_valid = r_v[3];

    // checks
    a_no_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !acc) else $error("input accepted during reciprocal");
    a_load_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_acc |-> (r_v == '0)) else $error("load accepted with tests in flight");
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_acc |=> busy) else $error("divider not started by load");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_hit)))
        else $error("stalled result changed");

endmodule
